FILE: rtl/sba_pkg.sv
// shared constants and types of the stream bitrate allocator
package sba_pkg;

  localparam int MAX_STREAMS = 16;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 32;
  localparam int RATE_W   = 32;
  localparam int STATUS_W = 2;

  localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W = $clog2(MAX_STREAMS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_STREAMS - 1);
  localparam int DIV_STEP_W = $clog2(RATE_W);
  localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(RATE_W - 1);

  localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEREGISTER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ESTIMATE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;
    logic              adj;
  } entry_t;

endpackage

FILE: rtl/sba_ram.sv
// generic single write port ram with registered read
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stream_bitrate_allocator.sv
// top level of the stream bitrate allocator: sequencer, stream table and divider
//
// Keeps up to MAX_STREAMS streams keyed by a 32-bit id, in one ram holding
// id, reported rate and adjustable flag and a second ram holding the
// allocated rate; the valid bits and the bandwidth estimate are flip-flops.
// One operation is handled at a time. Every register, deregister, report or
// query first scans the table one entry per cycle to find the id; a query
// then reads the allocated rate of its stream. A rate report for a known
// stream then scans the table again to sum the rates, runs a one-bit-per-cycle
// divider, and scans a third time to write the allocations; the divider is
// skipped when no stream is adjustable or the sum reaches the estimate. An
// estimate update or a kind without meaning skips the scan and goes straight
// to the output. A result held on a stalled output does not block acceptance
// of the next operation.
module stream_bitrate_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sba_pkg::KIND_W-1:0]    kind,
  input  logic [sba_pkg::ID_W-1:0]      stream_id,
  input  logic [sba_pkg::RATE_W-1:0]    rate,
  input  logic                          adjustable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sba_pkg::RATE_W-1:0]    allocated_rate,
  output logic [sba_pkg::STATUS_W-1:0]  status
);

  import sba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIND   = 9'b000000010,
    S_EXEC   = 9'b000000100,
    S_SUM    = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_ALLOC  = 9'b001000000,
    S_QREAD  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [MAX_STREAMS-1:0] entry_valid;
  logic [RATE_W-1:0]      bandwidth_estimate;

  logic [KIND_W-1:0]   op_kind;
  logic [ID_W-1:0]     op_id;
  logic [RATE_W-1:0]   op_rate;
  logic                op_adj;

  logic                found;
  logic [IDX_W-1:0]    slot;
  logic                free_found;
  logic [IDX_W-1:0]    free_slot;
  logic [IDX_W-1:0]    wslot;

  logic                issue_on;
  logic [IDX_W-1:0]    issue_idx;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_last;
  logic                rd_live;

  logic [RATE_W-1:0]   sum_total;
  logic [RATE_W-1:0]   sum_rem;
  logic [CNT_W-1:0]    adj_count;
  logic                full_mode;

  logic [RATE_W-1:0]   div_q;
  logic [CNT_W-1:0]    div_r;
  logic [DIV_STEP_W-1:0] div_step;
  logic [CNT_W:0]      div_sh;
  logic                div_ge;

  logic [RATE_W-1:0]   res_alloc;
  logic [STATUS_W-1:0] res_status;

  entry_t              main_wdata;
  entry_t              main_rdata;
  logic                main_we;
  logic                alloc_we;
  logic [IDX_W-1:0]    alloc_waddr;
  logic [RATE_W-1:0]   alloc_wdata;
  logic [RATE_W-1:0]   alloc_rdata;

  logic                out_free;

  sba_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_STREAMS)
  ) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (wslot),
    .wdata (main_wdata),
    .raddr (issue_idx),
    .rdata (main_rdata)
  );

  sba_ram #(
    .WIDTH (RATE_W),
    .DEPTH (MAX_STREAMS)
  ) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wdata (alloc_wdata),
    .raddr (slot),
    .rdata (alloc_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign wslot    = found ? slot : free_slot;
  assign rd_last  = rd_pend && (rd_idx == LAST_IDX);
  assign rd_live  = rd_pend && entry_valid[rd_idx];

  assign div_sh = {div_r, div_q[RATE_W-1]};
  assign div_ge = (div_sh >= {1'b0, adj_count});

  always_comb begin
    main_we     = 1'b0;
    main_wdata  = '{id: op_id, rate: '0, adj: 1'b0};
    alloc_we    = 1'b0;
    alloc_waddr = wslot;
    alloc_wdata = '0;
    unique case (state)
      S_EXEC: begin
        if (op_kind == KIND_REGISTER && (found || free_found)) begin
          main_we  = 1'b1;
          alloc_we = 1'b1;
        end else if (op_kind == KIND_REPORT && found) begin
          main_we    = 1'b1;
          main_wdata = '{id: op_id, rate: op_rate, adj: op_adj};
        end
      end
      S_ALLOC: begin
        alloc_we    = rd_live;
        alloc_waddr = rd_idx;
        if (full_mode) begin
          alloc_wdata = bandwidth_estimate;
        end else if (main_rdata.adj) begin
          alloc_wdata = div_q;
        end else begin
          alloc_wdata = main_rdata.rate;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      entry_valid        <= '0;
      bandwidth_estimate <= '0;
      issue_on           <= 1'b0;
      issue_idx          <= '0;
      rd_pend            <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      // table scan: one read issued per cycle, data back in the next cycle
      rd_pend <= issue_on && (state == S_FIND || state == S_SUM || state == S_ALLOC);
      rd_idx  <= issue_idx;
      if (issue_on) begin
        if (issue_idx == LAST_IDX) begin
          issue_on <= 1'b0;
        end else begin
          issue_idx <= IDX_W'(issue_idx + 1'b1);
        end
      end

      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind    <= kind;
            op_id      <= stream_id;
            op_rate    <= rate;
            op_adj     <= adjustable;
            found      <= 1'b0;
            free_found <= 1'b0;
            res_alloc  <= '0;
            res_status <= ST_DONE;
            priority if (kind == KIND_ESTIMATE) begin
              bandwidth_estimate <= rate;
              state              <= S_OUT;
            end else if (kind == KIND_REGISTER || kind == KIND_DEREGISTER ||
                         kind == KIND_REPORT || kind == KIND_QUERY) begin
              issue_on  <= 1'b1;
              issue_idx <= '0;
              state     <= S_FIND;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_FIND: begin
          if (rd_live && main_rdata.id == op_id) begin
            found <= 1'b1;
            slot  <= rd_idx;
          end
          if (rd_pend && !entry_valid[rd_idx] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= rd_idx;
          end
          if (rd_last) begin
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_OUT;
          unique case (op_kind)
            KIND_REGISTER: begin
              if (found || free_found) begin
                entry_valid[wslot] <= 1'b1;
              end else begin
                res_status <= ST_FULL;
              end
            end
            KIND_DEREGISTER: begin
              if (found) begin
                entry_valid[slot] <= 1'b0;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            KIND_REPORT: begin
              if (found) begin
                sum_total <= '0;
                sum_rem   <= bandwidth_estimate;
                adj_count <= '0;
                issue_on  <= 1'b1;
                issue_idx <= '0;
                state     <= S_SUM;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            KIND_QUERY: begin
              if (found) begin
                state <= S_QREAD;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end

        S_SUM: begin
          if (rd_live) begin
            sum_total <= sum_total + main_rdata.rate;
            if (main_rdata.adj) begin
              adj_count <= CNT_W'(adj_count + 1'b1);
            end else if (sum_rem >= main_rdata.rate) begin
              sum_rem <= sum_rem - main_rdata.rate;
            end else begin
              sum_rem <= '0;
            end
          end
          if (rd_last) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          full_mode <= (sum_total >= bandwidth_estimate);
          div_q     <= sum_rem;
          div_r     <= '0;
          div_step  <= '0;
          if (sum_total >= bandwidth_estimate || adj_count == '0) begin
            issue_on  <= 1'b1;
            issue_idx <= '0;
            state     <= S_ALLOC;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          // restoring division, one quotient bit per cycle
          div_q <= {div_q[RATE_W-2:0], div_ge};
          if (div_ge) begin
            div_r <= CNT_W'(div_sh - {1'b0, adj_count});
          end else begin
            div_r <= div_sh[CNT_W-1:0];
          end
          div_step <= DIV_STEP_W'(div_step + 1'b1);
          if (div_step == DIV_LAST) begin
            issue_on  <= 1'b1;
            issue_idx <= '0;
            state     <= S_ALLOC;
          end
        end

        S_ALLOC: begin
          if (rd_last) begin
            state <= S_OUT;
          end
        end

        S_QREAD: begin
          res_alloc <= alloc_rdata;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            allocated_rate <= res_alloc;
            status         <= res_status;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the divider never runs without an adjustable stream
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (adj_count != '0))
    else $error("divider started with zero divisor");

  // a finished operation always reaches the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result not presented");

  // an accepted transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted transfer dropped");

  // table read data only returns during a scan
  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_FIND || state == S_SUM || state == S_ALLOC))
    else $error("table read outside a scan");
`endif

endmodule

FILE: verif/stream_bitrate_allocator_tb.sv
// self-checking testbench of the stream bitrate allocator with its own table predictor
module stream_bitrate_allocator_tb;
  import sba_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int RANDOM_OPS = 1700;
  localparam int POOL_MAX = 20;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;
    logic              adj;
  } op_t;

  typedef struct {
    logic [RATE_W-1:0]   alloc;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [ID_W-1:0] stream_id = '0;
  logic [RATE_W-1:0] rate = '0;
  logic adjustable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RATE_W-1:0] allocated_rate;
  logic [STATUS_W-1:0] status;

  stream_bitrate_allocator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .stream_id(stream_id),
    .rate(rate),
    .adjustable(adjustable),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .allocated_rate(allocated_rate),
    .status(status)
  );

  always #4 clk = ~clk;

  // predicted stream table
  logic              tbl_valid [MAX_STREAMS];
  logic [ID_W-1:0]   tbl_id    [MAX_STREAMS];
  logic [RATE_W-1:0] tbl_rate  [MAX_STREAMS];
  logic              tbl_adj   [MAX_STREAMS];
  logic [RATE_W-1:0] tbl_alloc [MAX_STREAMS];
  logic [RATE_W-1:0] est_bw = '0;

  op_t    op_queue[$];
  reply_t due_replies[$];
  int     fail_count = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   in_gap = 0;
  int   out_wait = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;

  function automatic reply_t serve_op(input op_t op);
    reply_t rep;
    int slot;
    int unsigned n_adj;
    logic [RATE_W-1:0] total;
    logic [RATE_W-1:0] left;
    logic [RATE_W-1:0] share;
    rep.alloc = '0;
    rep.status = ST_DONE;
    slot = -1;
    for (int i = 0; i < MAX_STREAMS; i++)
      if (slot < 0 && tbl_valid[i] && tbl_id[i] == op.id) slot = i;
    case (op.kind)
      KIND_REGISTER: begin
        for (int i = 0; i < MAX_STREAMS; i++)
          if (slot < 0 && !tbl_valid[i]) slot = i;
        if (slot < 0) begin
          rep.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot] = op.id;
          tbl_rate[slot] = '0;
          tbl_adj[slot] = 1'b0;
          tbl_alloc[slot] = '0;
        end
      end
      KIND_DEREGISTER: begin
        if (slot < 0) rep.status = ST_NOT_FOUND;
        else tbl_valid[slot] = 1'b0;
      end
      KIND_REPORT: begin
        if (slot < 0) begin
          rep.status = ST_NOT_FOUND;
        end else begin
          tbl_rate[slot] = op.rate;
          tbl_adj[slot] = op.adj;
          total = '0;
          for (int i = 0; i < MAX_STREAMS; i++)
            if (tbl_valid[i]) total = total + tbl_rate[i];
          if (total >= est_bw) begin
            for (int i = 0; i < MAX_STREAMS; i++)
              if (tbl_valid[i]) tbl_alloc[i] = est_bw;
          end else begin
            left = est_bw;
            n_adj = 0;
            for (int i = 0; i < MAX_STREAMS; i++) begin
              if (tbl_valid[i]) begin
                if (tbl_adj[i]) begin
                  n_adj++;
                end else begin
                  tbl_alloc[i] = tbl_rate[i];
                  left = (left >= tbl_rate[i]) ? left - tbl_rate[i] : '0;
                end
              end
            end
            if (n_adj != 0) begin
              share = left / n_adj;
              for (int i = 0; i < MAX_STREAMS; i++)
                if (tbl_valid[i] && tbl_adj[i]) tbl_alloc[i] = share;
            end
          end
        end
      end
      KIND_QUERY: begin
        if (slot < 0) rep.status = ST_NOT_FOUND;
        else rep.alloc = tbl_alloc[slot];
      end
      KIND_ESTIMATE: est_bw = op.rate;
      default: ;
    endcase
    return rep;
  endfunction

  function automatic void add_op(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                 input logic [RATE_W-1:0] r, input logic a);
    op_t op;
    op.kind = k;
    op.id = id;
    op.rate = r;
    op.adj = a;
    op_queue.push_back(op);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return $urandom_range(0, 100000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom();
    endcase
  endfunction

  // input driver
  always @(negedge clk) begin : in_drive
    op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (op_queue.size() > 0) begin
        nxt = op_queue.pop_front();
        kind <= nxt.kind;
        stream_id <= nxt.id;
        rate <= nxt.rate;
        adjustable <= nxt.adj;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall driver
  always @(negedge clk) begin : out_drive
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else if (out_fire) begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      w = out_calm ? 0 : $urandom_range(0, 12);
      out_wait <= w;
      out_stall <= (w != 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch
    op_t seen;
    reply_t want;
    if (rst) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          $display("%0t unexpected transfer: alloc %0d status %0d", $time,
                   allocated_rate, status);
          fail_count++;
        end else begin
          want = due_replies.pop_front();
          if (allocated_rate !== want.alloc) begin
            $display("%0t allocated_rate expected %0d actual %0d", $time, want.alloc,
                     allocated_rate);
            fail_count++;
          end
          if (status !== want.status) begin
            $display("%0t status expected %0d actual %0d", $time, want.status, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen.kind = kind;
        seen.id = stream_id;
        seen.rate = rate;
        seen.adj = adjustable;
        due_replies.push_back(serve_op(seen));
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] id_pool [POOL_MAX];
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
    logic [ID_W-1:0] id_c;
    logic [ID_W-1:0] pick;
    logic [KIND_W-1:0] k;
    int pool_n;
    int len;
    int sel;
    int drain;
    for (int i = 0; i < MAX_STREAMS; i++) tbl_valid[i] = 1'b0;

    id_a = 32'h0000_0000;
    id_b = 32'hFFFF_FFFF;
    id_c = 32'h0000_3039;
    add_op(KIND_QUERY, id_a, $urandom(), 1'b1);
    add_op(KIND_DEREGISTER, id_a, $urandom(), 1'b0);
    add_op(KIND_REPORT, id_a, 32'd5, 1'b1);
    add_op(KIND_SPARE5, id_b, 32'hFFFF_FFFF, 1'b1);
    add_op(KIND_SPARE6, $urandom(), $urandom(), 1'b0);
    add_op(KIND_SPARE7, $urandom(), $urandom(), 1'b1);
    add_op(KIND_ESTIMATE, $urandom(), 32'd1000, 1'b0);
    add_op(KIND_REGISTER, id_a, $urandom(), 1'b1);
    add_op(KIND_REGISTER, id_b, $urandom(), 1'b0);
    add_op(KIND_REGISTER, id_a, $urandom(), 1'b1);
    add_op(KIND_REPORT, id_a, 32'd300, 1'b0);
    add_op(KIND_REPORT, id_b, 32'd200, 1'b1);
    add_op(KIND_QUERY, id_a, $urandom(), 1'b0);
    add_op(KIND_QUERY, id_b, $urandom(), 1'b1);
    add_op(KIND_REPORT, id_b, 32'd100, 1'b0);
    add_op(KIND_QUERY, id_b, $urandom(), 1'b0);
    add_op(KIND_REPORT, id_a, 32'hFFFF_FFFF, 1'b1);
    add_op(KIND_QUERY, id_a, $urandom(), 1'b0);
    add_op(KIND_REPORT, id_a, 32'h20, 1'b0);
    add_op(KIND_REPORT, id_b, 32'hFFFF_FFF0, 1'b0);
    add_op(KIND_REGISTER, id_c, $urandom(), 1'b0);
    add_op(KIND_REPORT, id_c, 32'd0, 1'b1);
    add_op(KIND_QUERY, id_c, $urandom(), 1'b0);
    add_op(KIND_ESTIMATE, $urandom(), 32'hFFFF_FFFF, 1'b1);
    add_op(KIND_REPORT, id_c, 32'd7, 1'b1);
    add_op(KIND_QUERY, id_b, $urandom(), 1'b0);
    add_op(KIND_ESTIMATE, $urandom(), 32'd0, 1'b0);
    add_op(KIND_REPORT, id_a, 32'd1, 1'b0);
    add_op(KIND_QUERY, id_c, $urandom(), 1'b1);
    add_op(KIND_DEREGISTER, id_b, $urandom(), 1'b1);
    add_op(KIND_QUERY, id_b, $urandom(), 1'b0);
    for (int i = 0; i < MAX_STREAMS; i++)
      add_op(KIND_DEREGISTER, ID_W'(i), $urandom(), 1'b0);
    add_op(KIND_DEREGISTER, id_a, $urandom(), 1'b0);
    add_op(KIND_DEREGISTER, id_c, $urandom(), 1'b0);

    // episodes over a small id pool so that most transfers hit known streams
    drain = op_queue.size() + RANDOM_OPS;
    while (op_queue.size() < drain) begin
      pool_n = $urandom_range(1, POOL_MAX);
      for (int i = 0; i < pool_n; i++) id_pool[i] = $urandom();
      if ($urandom_range(0, 3) == 0) id_pool[0] = 32'h0000_0000;
      if ($urandom_range(0, 3) == 0) id_pool[pool_n - 1] = 32'hFFFF_FFFF;
      add_op(KIND_ESTIMATE, $urandom(), pick_rate(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < pool_n; i++)
        if ($urandom_range(0, 3) != 0)
          add_op(KIND_REGISTER, id_pool[i], $urandom(), 1'($urandom_range(0, 1)));
      len = $urandom_range(20, 80);
      for (int j = 0; j < len; j++) begin
        sel = $urandom_range(0, 99);
        pick = id_pool[$urandom_range(0, pool_n - 1)];
        if (sel < 12) k = KIND_REGISTER;
        else if (sel < 18) k = KIND_DEREGISTER;
        else if (sel < 50) k = KIND_REPORT;
        else if (sel < 85) k = KIND_QUERY;
        else if (sel < 90) k = KIND_ESTIMATE;
        else if (sel < 93) begin
          case ($urandom_range(0, 2))
            0: k = KIND_SPARE5;
            1: k = KIND_SPARE6;
            default: k = KIND_SPARE7;
          endcase
        end else begin
          k = KIND_W'($urandom_range(0, 3));
          pick = $urandom();
        end
        add_op(k, pick, pick_rate(), 1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < pool_n; i++) add_op(KIND_DEREGISTER, id_pool[i], $urandom(), 1'b0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (due_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (due_replies.size() != 0) begin
      $display("%0t %0d expected transfers never arrived", $time, due_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
